// ----- hw/rtl/demand_pager_clock_replacement_macros.svh -----
// ----------------------------------------------------------------------------
// Demand pager assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef DEMAND_PAGER_CLOCK_REPLACEMENT_MACROS_SVH
`define DEMAND_PAGER_CLOCK_REPLACEMENT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define DPCR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define DPCR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/dpcr_pkg.sv -----
// ----------------------------------------------------------------------------
// Demand pager package
// Sizes, request and result types, page entry layout.
// ----------------------------------------------------------------------------
package dpcr_pkg;

    localparam int PROCESS_SLOTS = 8;
    localparam int VIRTUAL_PAGES = 256;
    localparam int FRAMES        = 64;
    localparam int DISK_BLOCKS   = 1024;

    localparam int SLOT_W      = 3;
    localparam int PAGE_W      = 8;
    localparam int FRAME_W     = 6;
    localparam int BLOCK_W     = 10;
    localparam int FRAME_CNT_W = 7;
    localparam int BLOCK_CNT_W = 11;
    localparam int EXT_W       = 9;
    localparam int ENT_ADDR_W  = SLOT_W + PAGE_W;
    localparam int ENTRIES     = PROCESS_SLOTS * VIRTUAL_PAGES;
    localparam int GUARD_W     = $clog2(FRAMES + 2);
    localparam int QUEUE_DEPTH = 2;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    localparam logic [FRAME_CNT_W-1:0] FRAMES_RESET = FRAME_CNT_W'(64);
    localparam logic [BLOCK_CNT_W-1:0] BLOCKS_RESET = BLOCK_CNT_W'(1024);

    localparam logic REG_FRAMES = 1'b0;
    localparam logic REG_BLOCKS = 1'b1;

    typedef enum logic [1:0] {
        OP_CREATE = 2'd0,
        OP_EXTEND = 2'd1,
        OP_FAULT  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        FILL_NONE = 2'd0,
        FILL_ZERO = 2'd1,
        FILL_DISK = 2'd2
    } t_fill;

    typedef struct packed {
        logic wr;
        logic rd;
        logic zero;
        logic dirty;
        logic referenced;
        logic live;
        logic res;
    } t_flags;

    typedef struct packed {
        logic [BLOCK_W-1:0] block;
        logic [FRAME_W-1:0] frame;
        t_flags             flags;
    } t_entry;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [PAGE_W-1:0] page;
    } t_ring_item;

    typedef struct packed {
        logic              bad;
        t_op               op;
        logic [SLOT_W-1:0] slot;
        logic [PAGE_W-1:0] page;
        logic              wr;
    } t_cmd;

    typedef struct packed {
        logic clearing;
        logic pop;
    } t_bk_ctl;

    typedef struct packed {
        logic [FRAME_CNT_W-1:0] frames_in_use;
        logic [BLOCK_CNT_W-1:0] blocks_in_use;
    } t_cfg;

    typedef struct packed {
        logic               status;
        logic [PAGE_W-1:0]  page_number;
        logic [FRAME_W-1:0] frame;
        logic               rd_grant;
        logic               wr_grant;
        t_fill              fill_action;
        logic [BLOCK_W-1:0] read_block;
        logic               evicted;
        logic [SLOT_W-1:0]  evict_process;
        logic [PAGE_W-1:0]  evict_page;
        logic               write_back;
        logic [BLOCK_W-1:0] write_block;
    } t_result;

endpackage

// ----- hw/rtl/demand_pager_clock_replacement.sv -----
// ----------------------------------------------------------------------------
// Demand pager with clock replacement
// Create / extend / fault requests over 8 process slots, second-chance
// eviction over the ring of resident frames, APB config of pool sizes.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                 Payload
//  request   in         i_valid / o_ready         opcode, process, page, write_access
//  result    out        o_valid / i_ready         status ... write_block
//  config    in         psel/penable/pwrite/pready  paddr, pwdata (prdata back)
//
//  Create sweeps the slot's 256 page entries, reading and then writing each
//  through the registered-read page table RAM; a fault that fills a frame
//  may first walk the clock hand over the ring entries.
//  Reset: the page table RAM is cleared first, all 2048 entries, one entry a
//  cycle with o_ready low; config writes are taken throughout.
//  Stalls: a finished result sits in the output register while the back end
//  waits; the two-deep request queue keeps taking requests until it is full.
//
module demand_pager_clock_replacement (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request channel
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [1:0]                          i_opcode,
    input  logic [dpcr_pkg::SLOT_W-1:0]         i_process,
    input  logic [dpcr_pkg::PAGE_W-1:0]         i_page,
    input  logic                                i_write_access,
    // result channel
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_status,
    output logic [dpcr_pkg::PAGE_W-1:0]         o_page_number,
    output logic [dpcr_pkg::FRAME_W-1:0]        o_frame,
    output logic                                o_rd_grant,
    output logic                                o_wr_grant,
    output logic [1:0]                          o_fill_action,
    output logic [dpcr_pkg::BLOCK_W-1:0]        o_read_block,
    output logic                                o_evicted,
    output logic [dpcr_pkg::SLOT_W-1:0]         o_evict_process,
    output logic [dpcr_pkg::PAGE_W-1:0]         o_evict_page,
    output logic                                o_write_back,
    output logic [dpcr_pkg::BLOCK_W-1:0]        o_write_block,
    // APB config
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dpcr_pkg::APB_AW-1:0]         paddr,
    input  logic [dpcr_pkg::APB_DW-1:0]         pwdata,
    output logic [dpcr_pkg::APB_DW-1:0]         prdata,
    output logic                                pready
);
    import dpcr_pkg::*;

    logic [FRAME_CNT_W-1:0] r_frames_in_use;
    logic [BLOCK_CNT_W-1:0] r_blocks_in_use;
    t_cfg                   cfg;
    t_cmd                   cmd;
    logic                   cmd_valid;
    t_bk_ctl                bk_ctl;
    t_result                res;

    // config registers: word index is paddr[2], low address bits ignored
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_in_use <= FRAMES_RESET;
            r_blocks_in_use <= BLOCKS_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_FRAMES: r_frames_in_use <= pwdata[FRAME_CNT_W-1:0];
                REG_BLOCKS: r_blocks_in_use <= pwdata[BLOCK_CNT_W-1:0];
                default:    r_frames_in_use <= r_frames_in_use;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_FRAMES: prdata = APB_DW'(r_frames_in_use);
            REG_BLOCKS: prdata = APB_DW'(r_blocks_in_use);
            default:    prdata = '0;
        endcase
    end

    assign cfg.frames_in_use = r_frames_in_use;
    assign cfg.blocks_in_use = r_blocks_in_use;

    // front: classify and queue
    dpcr_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_opcode       (i_opcode),
        .i_process      (i_process),
        .i_page         (i_page),
        .i_write_access (i_write_access),
        .i_ctl          (bk_ctl),
        .o_cmd          (cmd),
        .o_cmd_valid    (cmd_valid)
    );

    // back: page table, clock ring, result register
    dpcr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_ctl       (bk_ctl),
        .o_result    (res),
        .o_valid     (o_valid),
        .i_ready     (i_ready)
    );

    assign o_status        = res.status;
    assign o_page_number   = res.page_number;
    assign o_frame         = res.frame;
    assign o_rd_grant      = res.rd_grant;
    assign o_wr_grant      = res.wr_grant;
    assign o_fill_action   = res.fill_action;
    assign o_read_block    = res.read_block;
    assign o_evicted       = res.evicted;
    assign o_evict_process = res.evict_process;
    assign o_evict_page    = res.evict_page;
    assign o_write_back    = res.write_back;
    assign o_write_block   = res.write_block;

endmodule

// ----- hw/rtl/dpcr_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dpcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/dpcr_front.sv -----
// ----------------------------------------------------------------------------
// Demand pager front end
// Takes requests, flags unusable ones, queues them for the back end.
// ----------------------------------------------------------------------------
`include "demand_pager_clock_replacement_macros.svh"

module dpcr_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [1:0]               i_opcode,
    input  logic [dpcr_pkg::SLOT_W-1:0] i_process,
    input  logic [dpcr_pkg::PAGE_W-1:0] i_page,
    input  logic                     i_write_access,
    input  dpcr_pkg::t_bk_ctl        i_ctl,
    output dpcr_pkg::t_cmd           o_cmd,
    output logic                     o_cmd_valid
);
    import dpcr_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_q [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             push;
    t_cmd             cmd_in;

    assign o_ready = (r_cnt != CNT_W'(QUEUE_DEPTH)) && !i_ctl.clearing;
    assign push    = i_valid && o_ready;

    // unknown opcode or slot past the table fails without touching state
    always_comb begin
        cmd_in.op   = t_op'(i_opcode);
        cmd_in.slot = i_process;
        cmd_in.page = i_page;
        cmd_in.wr   = i_write_access;
        cmd_in.bad  = (32'(i_process) >= PROCESS_SLOTS) || (t_op'(i_opcode) == OP_NONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_q[r_wp] <= cmd_in;
                r_wp      <= (r_wp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_ctl.pop) begin
                r_rp <= (r_rp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (push && !i_ctl.pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!push && i_ctl.pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_cmd       = r_q[r_rp];
    assign o_cmd_valid = (r_cnt != '0);

    `DPCR_ASSERT_NOW(a_no_pop_empty, i_ctl.pop, r_cnt != '0, "pop from empty queue")
    `DPCR_ASSERT_NEXT(a_push_counts, push && !i_ctl.pop,
                      r_cnt == $past(r_cnt) + 1'b1, "queue count lost a push")
    `DPCR_ASSERT_NOW(a_full_stalls, r_cnt == CNT_W'(QUEUE_DEPTH), !o_ready,
                     "full queue still ready")

endmodule

// ----- hw/rtl/dpcr_back.sv -----
// ----------------------------------------------------------------------------
// Demand pager back end
// Runs create sweeps, extends, faults and the clock hand; holds the result.
// ----------------------------------------------------------------------------
`include "demand_pager_clock_replacement_macros.svh"

module dpcr_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dpcr_pkg::t_cfg    i_cfg,
    input  dpcr_pkg::t_cmd    i_cmd,
    input  logic              i_cmd_valid,
    output dpcr_pkg::t_bk_ctl o_ctl,
    output dpcr_pkg::t_result o_result,
    output logic              o_valid,
    input  logic              i_ready
);
    import dpcr_pkg::*;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DISPATCH,
        S_CR_RD,
        S_CR_WR,
        S_EX_WR,
        S_FT_CHK,
        S_CK_POP,
        S_CK_LOOK,
        S_CK_TEST,
        S_FT_FILL,
        S_OUT
    } t_state;

    t_state                 r_state;
    t_cmd                   r_cmd;
    logic [ENT_ADDR_W-1:0]  r_init_addr;
    logic [PAGE_W-1:0]      r_idx;
    logic [EXT_W-1:0]       r_ext [PROCESS_SLOTS];
    logic [FRAME_CNT_W-1:0] r_nff;
    logic [BLOCK_CNT_W-1:0] r_nfb;
    logic [FRAME_W-1:0]     r_head;
    logic [FRAME_CNT_W-1:0] r_count;
    logic [GUARD_W-1:0]     r_guard;
    t_entry                 r_ent;
    t_ring_item             r_item;
    logic [FRAME_W-1:0]     r_frame;
    t_result                r_res;
    t_result                r_out;
    logic                   r_out_valid;

    logic                   pe_we;
    logic [ENT_ADDR_W-1:0]  pe_waddr;
    logic [ENT_ADDR_W-1:0]  pe_raddr;
    t_entry                 pe_wdata;
    logic [$bits(t_entry)-1:0] pe_rdata_raw;
    t_entry                 pe_rd;
    logic                   rg_we;
    logic [FRAME_W-1:0]     rg_waddr;
    logic [FRAME_W-1:0]     rg_raddr;
    t_ring_item             rg_wdata;
    logic [$bits(t_ring_item)-1:0] rg_rdata_raw;
    t_ring_item             rg_rd;

    logic [FRAME_CNT_W-1:0] flim;
    logic [BLOCK_CNT_W-1:0] blim;
    logic [EXT_W-1:0]       ext_p;
    logic [FRAME_CNT_W:0]   push_sum;
    logic [FRAME_W-1:0]     push_addr;
    logic                   sweep_skip;
    t_flags                 hit_flags;
    t_entry                 fill_ent;

    assign pe_rd = t_entry'(pe_rdata_raw);
    assign rg_rd = t_ring_item'(rg_rdata_raw);

    assign flim  = (i_cfg.frames_in_use < FRAME_CNT_W'(FRAMES)) ?
                   i_cfg.frames_in_use : FRAME_CNT_W'(FRAMES);
    assign blim  = (i_cfg.blocks_in_use < BLOCK_CNT_W'(DISK_BLOCKS)) ?
                   i_cfg.blocks_in_use : BLOCK_CNT_W'(DISK_BLOCKS);
    assign ext_p = r_ext[r_cmd.slot];

    // tail of the ring: head + count, wrapped once
    assign push_sum  = (FRAME_CNT_W+1)'(r_head) + (FRAME_CNT_W+1)'(r_count);
    assign push_addr = (push_sum >= (FRAME_CNT_W+1)'(FRAMES)) ?
                       FRAME_W'(push_sum - (FRAME_CNT_W+1)'(FRAMES)) : FRAME_W'(push_sum);

    // referenced entry gets its second chance unless the guard ran out
    assign sweep_skip = pe_rd.flags.referenced && (32'(r_guard) <= FRAMES);

    always_comb begin
        hit_flags            = pe_rd.flags;
        hit_flags.rd         = 1'b1;
        hit_flags.referenced = 1'b1;
        if (r_cmd.wr) begin
            hit_flags.wr    = 1'b1;
            hit_flags.dirty = 1'b1;
            hit_flags.zero  = 1'b0;
        end
    end

    always_comb begin
        fill_ent                  = r_ent;
        fill_ent.frame            = r_frame;
        fill_ent.flags            = '0;
        fill_ent.flags.res        = 1'b1;
        fill_ent.flags.live       = 1'b1;
        fill_ent.flags.referenced = 1'b1;
        fill_ent.flags.rd         = 1'b1;
        fill_ent.flags.zero       = r_ent.flags.zero && !r_cmd.wr;
        fill_ent.flags.wr         = r_cmd.wr;
        fill_ent.flags.dirty      = r_cmd.wr;
    end

    // memory port steering
    always_comb begin
        pe_we    = 1'b0;
        pe_waddr = {r_cmd.slot, r_cmd.page};
        pe_wdata = pe_rd;
        pe_raddr = {r_cmd.slot, r_cmd.page};
        rg_we    = 1'b0;
        rg_waddr = push_addr;
        rg_wdata = r_item;
        rg_raddr = r_head;
        unique case (r_state)
            S_INIT: begin
                pe_we    = 1'b1;
                pe_waddr = r_init_addr;
                pe_wdata = '0;
            end
            S_DISPATCH: begin
                if (r_cmd.op == OP_EXTEND) begin
                    pe_raddr = {r_cmd.slot, ext_p[PAGE_W-1:0]};
                end
            end
            S_CR_RD: begin
                pe_raddr = {r_cmd.slot, r_idx};
            end
            S_CR_WR: begin
                pe_we              = 1'b1;
                pe_waddr           = {r_cmd.slot, r_idx};
                pe_wdata.block     = '0;
                pe_wdata.flags     = '0;
                pe_wdata.flags.res = pe_rd.flags.res;
            end
            S_EX_WR: begin
                pe_we               = 1'b1;
                pe_waddr            = {r_cmd.slot, ext_p[PAGE_W-1:0]};
                pe_wdata.block      = r_nfb[BLOCK_W-1:0];
                pe_wdata.flags      = '0;
                pe_wdata.flags.res  = pe_rd.flags.res;
                pe_wdata.flags.zero = 1'b1;
            end
            S_FT_CHK: begin
                if (pe_rd.flags.res && pe_rd.flags.live) begin
                    pe_we          = 1'b1;
                    pe_wdata.flags = hit_flags;
                end
            end
            S_CK_LOOK: begin
                pe_raddr = {rg_rd.slot, rg_rd.page};
            end
            S_CK_TEST: begin
                pe_we    = 1'b1;
                pe_waddr = {r_item.slot, r_item.page};
                if (sweep_skip) begin
                    pe_wdata.flags.referenced = 1'b0;
                    pe_wdata.flags.rd         = 1'b0;
                    pe_wdata.flags.wr         = 1'b0;
                    rg_we                     = 1'b1;
                end else begin
                    pe_wdata.frame            = '0;
                    pe_wdata.flags.res        = 1'b0;
                    pe_wdata.flags.live       = 1'b0;
                    pe_wdata.flags.referenced = 1'b0;
                    pe_wdata.flags.dirty      = 1'b0;
                    pe_wdata.flags.rd         = 1'b0;
                    pe_wdata.flags.wr         = 1'b0;
                end
            end
            S_FT_FILL: begin
                pe_we    = 1'b1;
                pe_wdata = fill_ent;
                rg_we    = !r_ent.flags.res;
                rg_wdata = '{slot: r_cmd.slot, page: r_cmd.page};
            end
            default: begin
            end
        endcase
    end

    dpcr_ram #(.WIDTH($bits(t_entry)), .DEPTH(ENTRIES)) u_page_ram (
        .i_clk   (i_clk),
        .i_we    (pe_we),
        .i_waddr (pe_waddr),
        .i_wdata (pe_wdata),
        .i_raddr (pe_raddr),
        .o_rdata (pe_rdata_raw)
    );

    dpcr_ram #(.WIDTH($bits(t_ring_item)), .DEPTH(FRAMES)) u_ring_ram (
        .i_clk   (i_clk),
        .i_we    (rg_we),
        .i_waddr (rg_waddr),
        .i_wdata (rg_wdata),
        .i_raddr (rg_raddr),
        .o_rdata (rg_rdata_raw)
    );

    assign o_ctl.clearing = (r_state == S_INIT);
    assign o_ctl.pop      = (r_state == S_IDLE) && i_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_init_addr <= '0;
            r_nff       <= '0;
            r_nfb       <= '0;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < PROCESS_SLOTS; i++) begin
                r_ext[i] <= '0;
            end
        end else begin
            // S_OUT reloads the output register itself
            if (r_out_valid && i_ready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_INIT: begin
                    r_init_addr <= r_init_addr + 1'b1;
                    if (r_init_addr == ENT_ADDR_W'(ENTRIES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd   <= i_cmd;
                        r_res   <= '0;
                        r_state <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    if (r_cmd.bad) begin
                        r_res.status <= 1'b1;
                        r_state      <= S_OUT;
                    end else begin
                        unique case (r_cmd.op)
                            OP_CREATE: begin
                                r_idx   <= '0;
                                r_state <= S_CR_RD;
                            end
                            OP_EXTEND: begin
                                if (r_nfb >= blim || ext_p >= EXT_W'(VIRTUAL_PAGES)) begin
                                    r_res.status <= 1'b1;
                                    r_state      <= S_OUT;
                                end else begin
                                    r_state <= S_EX_WR;
                                end
                            end
                            OP_FAULT: begin
                                if (EXT_W'(r_cmd.page) >= ext_p) begin
                                    r_res.status <= 1'b1;
                                    r_state      <= S_OUT;
                                end else begin
                                    r_state <= S_FT_CHK;
                                end
                            end
                            default: begin
                                r_res.status <= 1'b1;
                                r_state      <= S_OUT;
                            end
                        endcase
                    end
                end
                S_CR_RD: begin
                    r_state <= S_CR_WR;
                end
                S_CR_WR: begin
                    if (r_idx == PAGE_W'(VIRTUAL_PAGES - 1)) begin
                        r_ext[r_cmd.slot] <= '0;
                        r_state           <= S_OUT;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_CR_RD;
                    end
                end
                S_EX_WR: begin
                    r_nfb               <= r_nfb + 1'b1;
                    r_ext[r_cmd.slot]   <= ext_p + 1'b1;
                    r_res.page_number   <= ext_p[PAGE_W-1:0];
                    r_state             <= S_OUT;
                end
                S_FT_CHK: begin
                    r_ent   <= pe_rd;
                    r_guard <= '0;
                    if (pe_rd.flags.res && pe_rd.flags.live) begin
                        r_res.page_number <= r_cmd.page;
                        r_res.frame       <= pe_rd.frame;
                        r_res.rd_grant    <= 1'b1;
                        r_res.wr_grant    <= hit_flags.wr;
                        r_state           <= S_OUT;
                    end else if (pe_rd.flags.res) begin
                        r_frame <= pe_rd.frame;
                        r_state <= S_FT_FILL;
                    end else if (r_nff < flim) begin
                        r_frame <= r_nff[FRAME_W-1:0];
                        r_nff   <= r_nff + 1'b1;
                        r_state <= S_FT_FILL;
                    end else if (r_count != '0) begin
                        r_state <= S_CK_POP;
                    end else begin
                        r_res.status <= 1'b1;
                        r_state      <= S_OUT;
                    end
                end
                S_CK_POP: begin
                    r_head  <= (r_head == FRAME_W'(FRAMES - 1)) ? '0 : r_head + 1'b1;
                    r_count <= r_count - 1'b1;
                    r_state <= S_CK_LOOK;
                end
                S_CK_LOOK: begin
                    r_item  <= rg_rd;
                    r_state <= S_CK_TEST;
                end
                S_CK_TEST: begin
                    if (sweep_skip) begin
                        r_count <= r_count + 1'b1;
                        r_guard <= r_guard + 1'b1;
                        r_state <= S_CK_POP;
                    end else begin
                        r_res.evicted       <= 1'b1;
                        r_res.evict_process <= r_item.slot;
                        r_res.evict_page    <= r_item.page;
                        r_res.write_back    <= pe_rd.flags.dirty;
                        r_res.write_block   <= pe_rd.flags.dirty ? pe_rd.block : '0;
                        r_frame             <= pe_rd.frame;
                        r_state             <= S_FT_FILL;
                    end
                end
                S_FT_FILL: begin
                    if (!r_ent.flags.res) begin
                        r_count <= r_count + 1'b1;
                    end
                    r_res.fill_action <= r_ent.flags.zero ? FILL_ZERO : FILL_DISK;
                    r_res.read_block  <= r_ent.flags.zero ? '0 : r_ent.block;
                    r_res.page_number <= r_cmd.page;
                    r_res.frame       <= r_frame;
                    r_res.rd_grant    <= 1'b1;
                    r_res.wr_grant    <= r_cmd.wr;
                    r_state           <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || i_ready) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_result = r_out;
    assign o_valid  = r_out_valid;

    `DPCR_ASSERT_NOW(a_ring_cap, 1'b1, r_count <= FRAME_CNT_W'(FRAMES),
                     "clock ring holds more pages than frames")
    `DPCR_ASSERT_NOW(a_frames_cap, 1'b1, r_nff <= FRAME_CNT_W'(FRAMES),
                     "free frame count ran past the frame pool")
    `DPCR_ASSERT_NEXT(a_pop_dispatch, o_ctl.pop, r_state == S_DISPATCH,
                      "popped request not dispatched")

endmodule

// ----- verif/demand_pager_clock_replacement_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Demand pager testbench
// Drives create/extend/fault requests with random gaps and result stalls,
// predicts every result with a local page-table and clock-ring copy, and
// walks the frame and disk-block pool limits through several settings.
// ----------------------------------------------------------------------------
module demand_pager_clock_replacement_test;
    import dpcr_pkg::*;

    localparam int REG_FRAMES_ADDR = 0;
    localparam int REG_BLOCKS_ADDR = 4;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [1:0]           i_opcode = OP_CREATE;
    logic [SLOT_W-1:0]    i_process = '0;
    logic [PAGE_W-1:0]    i_page = '0;
    logic                 i_write_access = 1'b0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic                 o_status;
    logic [PAGE_W-1:0]    o_page_number;
    logic [FRAME_W-1:0]   o_frame;
    logic                 o_rd_grant;
    logic                 o_wr_grant;
    logic [1:0]           o_fill_action;
    logic [BLOCK_W-1:0]   o_read_block;
    logic                 o_evicted;
    logic [SLOT_W-1:0]    o_evict_process;
    logic [PAGE_W-1:0]    o_evict_page;
    logic                 o_write_back;
    logic [BLOCK_W-1:0]   o_write_block;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [APB_AW-1:0]    paddr = '0;
    logic [APB_DW-1:0]    pwdata = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    demand_pager_clock_replacement uut (.*);

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ---- local copy of the pager state --------------------------------------
    logic [BLOCK_W-1:0]  pt_block [ENTRIES];
    logic [FRAME_W-1:0]  pt_frame [ENTRIES];
    t_flags              pt_flags [ENTRIES];
    t_ring_item          hand_ring [FRAMES];
    int                  hand_head, hand_count;
    int                  pages_extended [PROCESS_SLOTS];
    int                  frames_taken, blocks_taken;
    int                  lim_frames, lim_blocks;

    t_result             pending_results [$];
    int                  errors = 0;
    int                  results_seen = 0;
    int                  fails_seen = 0;
    int                  evictions_seen = 0;
    int                  writebacks_seen = 0;
    bit                  rx_busy_mode = 1'b0;   // stretches of back-to-back ready
    bit                  tx_busy_mode = 1'b0;   // stretches of back-to-back valid

    function automatic void clear_pager();
        for (int i = 0; i < ENTRIES; i++) begin
            pt_block[i] = '0;
            pt_frame[i] = '0;
            pt_flags[i] = '0;
        end
        for (int s = 0; s < PROCESS_SLOTS; s++) pages_extended[s] = 0;
        hand_head = 0;
        hand_count = 0;
        frames_taken = 0;
        blocks_taken = 0;
        lim_frames = 64;
        lim_blocks = 1024;
    endfunction

    function automatic t_ring_item hand_pop();
        t_ring_item it;
        it = hand_ring[hand_head % FRAMES];
        hand_head = (hand_head + 1) % FRAMES;
        hand_count--;
        return it;
    endfunction

    function automatic void hand_push(t_ring_item it);
        hand_ring[(hand_head + hand_count) % FRAMES] = it;
        hand_count++;
    endfunction

    // Works out the result of one request and updates the local state.
    function automatic t_result predict_pager(t_op op, logic [SLOT_W-1:0] slot,
                                              logic [PAGE_W-1:0] page, logic wr);
        t_result    r;
        int         base, e, ve, guard, fr;
        t_ring_item it, ni;
        r = '0;
        base = int'(slot) * VIRTUAL_PAGES;
        if (op == OP_NONE) begin
            r.status = 1'b1;
            return r;
        end
        if (op == OP_CREATE) begin
            // resident pages become orphans: only the resident mark survives
            for (int p = 0; p < VIRTUAL_PAGES; p++) begin
                pt_flags[base + p] = '{res: pt_flags[base + p].res, default: 1'b0};
                pt_block[base + p] = '0;
            end
            pages_extended[slot] = 0;
            return r;
        end
        if (op == OP_EXTEND) begin
            if (blocks_taken >= (lim_blocks < DISK_BLOCKS ? lim_blocks : DISK_BLOCKS) ||
                pages_extended[slot] >= VIRTUAL_PAGES) begin
                r.status = 1'b1;
                return r;
            end
            e = base + pages_extended[slot];
            pt_block[e] = BLOCK_W'(blocks_taken);
            blocks_taken++;
            pt_flags[e] = '{res: pt_flags[e].res, zero: 1'b1, default: 1'b0};
            r.page_number = PAGE_W'(pages_extended[slot]);
            pages_extended[slot]++;
            return r;
        end
        // fault
        if (int'(page) >= pages_extended[slot]) begin
            r.status = 1'b1;
            return r;
        end
        e = base + int'(page);
        if (pt_flags[e].res && pt_flags[e].live) begin
            pt_flags[e].rd = 1'b1;
            pt_flags[e].referenced = 1'b1;
            if (wr) begin
                pt_flags[e].wr = 1'b1;
                pt_flags[e].dirty = 1'b1;
                pt_flags[e].zero = 1'b0;
            end
            r.page_number = page;
            r.frame = pt_frame[e];
            r.rd_grant = 1'b1;
            r.wr_grant = pt_flags[e].wr;
            return r;
        end
        if (pt_flags[e].res) begin
            fr = int'(pt_frame[e]);            // orphan refills its own frame
        end else if (frames_taken < (lim_frames < FRAMES ? lim_frames : FRAMES)) begin
            fr = frames_taken;
            frames_taken++;
        end else if (hand_count > 0) begin
            it = hand_pop();
            ve = int'(it.slot) * VIRTUAL_PAGES + int'(it.page);
            guard = 0;
            // second chance: referenced entries lose their grants and requeue
            while (pt_flags[ve].referenced && guard <= FRAMES) begin
                pt_flags[ve].referenced = 1'b0;
                pt_flags[ve].rd = 1'b0;
                pt_flags[ve].wr = 1'b0;
                hand_push(it);
                it = hand_pop();
                ve = int'(it.slot) * VIRTUAL_PAGES + int'(it.page);
                guard++;
            end
            r.evicted = 1'b1;
            r.evict_process = it.slot;
            r.evict_page = it.page;
            if (pt_flags[ve].dirty) begin
                r.write_back = 1'b1;
                r.write_block = pt_block[ve];
            end
            fr = int'(pt_frame[ve]);
            pt_flags[ve] = '{zero: pt_flags[ve].zero, default: 1'b0};
            pt_frame[ve] = '0;
        end else begin
            r.status = 1'b1;
            return r;
        end
        if (pt_flags[e].zero) begin
            r.fill_action = FILL_ZERO;
        end else begin
            r.fill_action = FILL_DISK;
            r.read_block = pt_block[e];
        end
        if (!pt_flags[e].res) begin
            ni.slot = slot;
            ni.page = page;
            hand_push(ni);
        end
        pt_frame[e] = FRAME_W'(fr);
        pt_flags[e] = '{zero: pt_flags[e].zero, res: 1'b1, live: 1'b1,
                        referenced: 1'b1, rd: 1'b1, default: 1'b0};
        if (wr) begin
            pt_flags[e].wr = 1'b1;
            pt_flags[e].dirty = 1'b1;
            pt_flags[e].zero = 1'b0;
        end
        r.page_number = page;
        r.frame = FRAME_W'(fr);
        r.rd_grant = 1'b1;
        r.wr_grant = wr;
        return r;
    endfunction

    // ---- request side -------------------------------------------------------
    // Valid stays up across back-to-back requests; payload changes at the
    // accepting edge. Acceptance is judged from o_ready at the falling edge,
    // which holds through the next rising edge.
    task automatic send_request(t_op op, logic [SLOT_W-1:0] slot, logic [PAGE_W-1:0] page,
                                logic wr, bit typed, t_result typed_res);
        int      gap;
        t_result r;
        gap = tx_busy_mode ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_opcode <= op;
        i_process <= slot;
        i_page <= page;
        i_write_access <= wr;
        @(negedge i_clk);
        while (!o_ready) @(negedge i_clk);
        @(posedge i_clk);
        r = predict_pager(op, slot, page, wr);
        pending_results.insert(pending_results.size(), typed ? typed_res : r);
    endtask

    task automatic quiet_bus();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);        // no request lives without a result
    endtask

    // setup cycle, then access cycle; register loads at the edge after it
    task automatic apb_write(int addr, int value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= APB_AW'(addr);
        pwdata <= APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        if (addr == REG_FRAMES_ADDR) lim_frames = value & 'h7F;
        else lim_blocks = value & 'h7FF;
    endtask

    task automatic random_requests(int count);
        int  roll, slot, page;
        t_op op;
        for (int n = 0; n < count; n++) begin
            if (n % 50 == 0) tx_busy_mode = ($urandom_range(0, 3) == 0);
            roll = $urandom_range(0, 99);
            // favor the low slots so rings fill and pages get re-faulted
            slot = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 2);
            page = $urandom_range(0, 255);
            if (roll < 2) op = OP_NONE;
            else if (roll < 5) op = OP_CREATE;
            else if (roll < 25) op = OP_EXTEND;
            else op = OP_FAULT;
            if (op == OP_FAULT && pages_extended[slot] > 0 && $urandom_range(0, 9) != 0)
                page = $urandom_range(0, pages_extended[slot] - 1);
            send_request(op, SLOT_W'(slot), PAGE_W'(page), 1'($urandom_range(0, 1)),
                         1'b0, '0);
        end
    endtask

    // directed table: typed rows give an expectation that is obvious
    typedef struct {
        t_op               op;
        logic [SLOT_W-1:0] slot;
        logic [PAGE_W-1:0] page;
        logic              wr;
        bit                typed;
        logic              status;
        logic [PAGE_W-1:0] pnum;
    } t_step;

    t_step steps [16];

    initial begin
        t_result tr;
        steps = '{
            '{OP_FAULT,  3'd0, 8'd0,   1'b0, 1'b1, 1'b1, 8'd0},   // nothing extended
            '{OP_NONE,   3'd7, 8'hFF,  1'b1, 1'b1, 1'b1, 8'd0},   // unused opcode
            '{OP_CREATE, 3'd0, 8'd0,   1'b0, 1'b1, 1'b0, 8'd0},
            '{OP_EXTEND, 3'd0, 8'd0,   1'b0, 1'b1, 1'b0, 8'd0},
            '{OP_EXTEND, 3'd0, 8'd0,   1'b0, 1'b1, 1'b0, 8'd1},
            '{OP_EXTEND, 3'd7, 8'd0,   1'b0, 1'b1, 1'b0, 8'd0},
            '{OP_FAULT,  3'd0, 8'd0,   1'b0, 1'b0, 1'b0, 8'd0},   // zero fill, new frame
            '{OP_FAULT,  3'd0, 8'd0,   1'b1, 1'b0, 1'b0, 8'd0},   // write upgrade on hit
            '{OP_FAULT,  3'd0, 8'd1,   1'b1, 1'b0, 1'b0, 8'd0},
            '{OP_FAULT,  3'd7, 8'd0,   1'b0, 1'b0, 1'b0, 8'd0},
            '{OP_FAULT,  3'd0, 8'd2,   1'b0, 1'b1, 1'b1, 8'd0},   // beyond extension
            '{OP_FAULT,  3'd0, 8'd255, 1'b1, 1'b1, 1'b1, 8'd0},
            '{OP_CREATE, 3'd0, 8'd0,   1'b0, 1'b1, 1'b0, 8'd0},   // leaves orphans
            '{OP_EXTEND, 3'd0, 8'd0,   1'b0, 1'b1, 1'b0, 8'd0},
            '{OP_FAULT,  3'd0, 8'd0,   1'b0, 1'b0, 1'b0, 8'd0},   // orphan refill
            '{OP_FAULT,  3'd7, 8'd0,   1'b1, 1'b0, 1'b0, 8'd0}
        };
        clear_pager();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        apb_write(REG_FRAMES_ADDR, 64);
        apb_write(REG_BLOCKS_ADDR, 1024);
        foreach (steps[k]) begin
            tr = '0;
            tr.status = steps[k].status;
            tr.page_number = steps[k].pnum;
            send_request(steps[k].op, steps[k].slot, steps[k].page, steps[k].wr,
                         steps[k].typed, tr);
        end
        random_requests(200);

        // few frames: the clock hand does the work
        quiet_bus();
        apb_write(REG_FRAMES_ADDR, 3);
        random_requests(500);

        quiet_bus();
        apb_write(REG_FRAMES_ADDR, 1);
        random_requests(300);

        quiet_bus();
        apb_write(REG_FRAMES_ADDR, 64);
        random_requests(400);

        // block pool already spent: every extend fails
        quiet_bus();
        apb_write(REG_BLOCKS_ADDR, 1);
        apb_write(REG_FRAMES_ADDR, 2);
        random_requests(250);

        quiet_bus();
        apb_write(REG_BLOCKS_ADDR, 1024);
        apb_write(REG_FRAMES_ADDR, 40);
        random_requests(250);

        quiet_bus();
        $display("covered %0d results: %0d failures, %0d evictions, %0d write-backs",
                 results_seen, fails_seen, evictions_seen, writebacks_seen);
        if (errors == 0) begin
            $display("demand_pager_clock_replacement_test OK");
        end else begin
            $display("demand_pager_clock_replacement_test NOT OK");
        end
        $finish;
    end

    // ---- result side --------------------------------------------------------
    task automatic check_field(string name, logic [31:0] exp, logic [31:0] got);
        if (exp !== got) begin
            errors++;
            $display("%0t: %s expected %0h got %0h", $time, name, exp, got);
        end
    endtask

    initial begin
        int      stall;
        t_result got, want;
        forever begin
            if (results_seen % 40 == 0) rx_busy_mode = ($urandom_range(0, 3) == 0);
            stall = rx_busy_mode ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(negedge i_clk);
            while (!(o_valid && i_rst_n)) @(negedge i_clk);
            got.status = o_status;
            got.page_number = o_page_number;
            got.frame = o_frame;
            got.rd_grant = o_rd_grant;
            got.wr_grant = o_wr_grant;
            got.fill_action = t_fill'(o_fill_action);
            got.read_block = o_read_block;
            got.evicted = o_evicted;
            got.evict_process = o_evict_process;
            got.evict_page = o_evict_page;
            got.write_back = o_write_back;
            got.write_block = o_write_block;
            @(posedge i_clk);
            results_seen++;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result with no request outstanding, expected none got %p",
                         $time, got);
            end else begin
                want = pending_results.pop_front();
                fails_seen += want.status;
                evictions_seen += want.evicted;
                writebacks_seen += want.write_back;
                check_field("status", want.status, got.status);
                check_field("page_number", want.page_number, got.page_number);
                check_field("frame", want.frame, got.frame);
                check_field("rd_grant", want.rd_grant, got.rd_grant);
                check_field("wr_grant", want.wr_grant, got.wr_grant);
                check_field("fill_action", want.fill_action, got.fill_action);
                check_field("read_block", want.read_block, got.read_block);
                check_field("evicted", want.evicted, got.evicted);
                check_field("evict_process", want.evict_process, got.evict_process);
                check_field("evict_page", want.evict_page, got.evict_page);
                check_field("write_back", want.write_back, got.write_back);
                check_field("write_block", want.write_block, got.write_block);
            end
        end
    end

    // run limit: far beyond the slowest legal run (creates dominate)
    initial begin
        #40_000_000;
        $display("demand_pager_clock_replacement_test NOT OK");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/dpcr_pkg.sv
hw/rtl/dpcr_ram.sv
hw/rtl/dpcr_front.sv
hw/rtl/dpcr_back.sv
hw/rtl/demand_pager_clock_replacement.sv
verif/demand_pager_clock_replacement_test.sv
